FILE: rtl/rsd_pkg.sv
package rsd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } rsd_in_t;

  typedef struct packed {
    logic               kind;
    logic [31:0]        address;
    logic [15:0]        colour;
    logic [7:0]         run_length;
    logic               shadow;
    logic [15:0]        width;
    logic [15:0]        height;
    logic signed [15:0] x_offset;
    logic signed [15:0] y_offset;
    logic               image_done;
    logic               out_of_range;
  } rsd_out_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_COUNT,
    PH_JUMP,
    PH_LOW,
    PH_HIGH,
    PH_IDLE
  } rsd_phase_t;

  localparam int CFG_DATA_W = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IMAGE_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OFFSET_ODD = 1'b1;

  localparam logic [2:0] TYPE_LANDSCAPE = 3'd0;
  localparam logic [2:0] TYPE_OBJECT    = 3'd1;
  localparam logic [2:0] TYPE_SHADOW    = 3'd2;
  localparam logic [2:0] TYPE_GUI       = 3'd3;

  localparam logic [3:0] HDR_LEN_LANDSCAPE = 4'd6;
  localparam logic [3:0] HDR_LEN_OBJECT    = 4'd14;
  localparam logic [3:0] HDR_LEN_GUI       = 4'd10;
  localparam logic [3:0] HDR_MAGIC_LEN     = 4'd4;

  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_HEADER = 1'b1;

  localparam int LINE_END_BIT = 7;

endpackage

FILE: rtl/rsd_queue.sv
module rsd_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  rsd_pkg::rsd_in_t in_word,
  output logic            in_ready,
  output logic            q_valid,
  output rsd_pkg::rsd_in_t q_word,
  input  logic            q_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rsd_pkg::rsd_in_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign in_ready = (count_r != CW'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_word   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = CW'(count_r + 1'b1);
      2'b01:   count_nxt = CW'(count_r - 1'b1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_word;
    end
  end

endmodule

FILE: rtl/rsd_decode.sv
module rsd_decode (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               q_valid,
  input  rsd_pkg::rsd_in_t                   q_word,
  output logic                               q_ready,
  output logic                               out_valid,
  output rsd_pkg::rsd_out_t                  out_word,
  input  logic                               out_ready
);

  logic [2:0]          image_type_r;
  logic                offset_odd_r;

  rsd_pkg::rsd_phase_t phase_r, phase_nxt, phase_e;
  logic [3:0]          hidx_r, hidx_nxt, hidx_e;
  logic [15:0]         w_r, w_nxt, w_hdr;
  logic [15:0]         h_r, h_nxt, h_hdr;
  logic [15:0]         x_r, x_nxt, x_hdr;
  logic [15:0]         y_r, y_nxt, y_hdr;
  logic [15:0]         row_r, row_nxt;
  logic [15:0]         col_r, col_nxt;
  logic [31:0]         loc_r, loc_nxt;
  logic [31:0]         rbase_r, rbase_nxt;
  logic [7:0]          run_r, run_nxt;
  logic [7:0]          jump_r, jump_nxt;
  logic [7:0]          pl_r, pl_nxt;
  logic [7:0]          low_r, low_nxt;
  logic [31:0]         area_r;

  rsd_pkg::rsd_out_t   res;
  logic                emit_c;
  logic                fire;
  logic                out_space;
  logic                out_valid_r, out_valid_nxt;
  rsd_pkg::rsd_out_t   out_word_r;

  logic [7:0]          b;
  logic                type_obj, type_bad, shadow_img;
  logic [3:0]          hdr_len, hdr_base, hdr_pos;
  logic                hdr_in, hdr_more, hdr_empty;
  logic [16:0]         col_room;
  logic                run_ok;
  logic [31:0]         loc_j, line_loc, sh_diff;
  logic [15:0]         row_inc;
  logic                img_end;
  logic [7:0]          pl_dec, sh_inside;
  logic                pix_last, sh_over;

  assign b          = q_word.data_byte;
  assign phase_e    = q_word.first ? rsd_pkg::PH_HEADER : phase_r;
  assign hidx_e     = q_word.first ? 4'd0 : hidx_r;
  assign type_obj   = (image_type_r == rsd_pkg::TYPE_OBJECT) ||
                      (image_type_r == rsd_pkg::TYPE_SHADOW);
  assign type_bad   = (image_type_r > rsd_pkg::TYPE_GUI);
  assign shadow_img = (image_type_r == rsd_pkg::TYPE_SHADOW);

  always_comb begin
    if (image_type_r == rsd_pkg::TYPE_LANDSCAPE) begin
      hdr_len = rsd_pkg::HDR_LEN_LANDSCAPE;
    end else if (type_obj) begin
      hdr_len = rsd_pkg::HDR_LEN_OBJECT - {3'd0, offset_odd_r};
    end else begin
      hdr_len = rsd_pkg::HDR_LEN_GUI - {3'd0, offset_odd_r};
    end
  end

  assign hdr_base = type_obj ? rsd_pkg::HDR_MAGIC_LEN : 4'd0;
  assign hdr_pos  = hidx_e - hdr_base;
  assign hdr_in   = (hidx_e < hdr_len) && (hidx_e >= hdr_base);
  assign hdr_more = (({1'b0, hidx_e} + 5'd1) < {1'b0, hdr_len});

  assign col_room = {1'b0, w_r} - {1'b0, col_r};
  assign run_ok   = (run_r != 8'd0) &&
                    (col_room[16] || ({8'd0, run_r} <= col_room[15:0]));
  assign loc_j    = loc_r + {25'd0, b[6:0]};
  assign row_inc  = row_r + 16'd1;
  assign img_end  = (row_inc >= h_r);
  assign line_loc = rbase_r + {16'd0, w_r};
  assign pl_dec   = pl_r - 8'd1;
  assign pix_last = (pl_dec == 8'd0);
  assign sh_over  = (loc_j >= area_r);
  assign sh_diff  = area_r - loc_j;

  always_comb begin
    if (sh_over) begin
      sh_inside = 8'd0;
    end else if (sh_diff < {24'd0, run_r}) begin
      sh_inside = sh_diff[7:0];
    end else begin
      sh_inside = run_r;
    end
  end

  always_comb begin
    w_hdr = q_word.first ? 16'd0 : w_r;
    h_hdr = q_word.first ? 16'd0 : h_r;
    x_hdr = q_word.first ? 16'd0 : x_r;
    y_hdr = q_word.first ? 16'd0 : y_r;
    if (phase_e == rsd_pkg::PH_HEADER && !type_bad && hdr_in) begin
      unique case (hdr_pos)
        4'd0: w_hdr[7:0]  = b;
        4'd1: w_hdr[15:8] = b;
        4'd2: h_hdr[7:0]  = b;
        4'd3: h_hdr[15:8] = b;
        4'd4: if (image_type_r != rsd_pkg::TYPE_LANDSCAPE) x_hdr[7:0]  = b;
        4'd5: if (image_type_r != rsd_pkg::TYPE_LANDSCAPE) x_hdr[15:8] = b;
        4'd6: if (image_type_r != rsd_pkg::TYPE_LANDSCAPE) y_hdr[7:0]  = b;
        4'd7: if (image_type_r != rsd_pkg::TYPE_LANDSCAPE) y_hdr[15:8] = b;
        default: ;
      endcase
    end
  end

  assign hdr_empty = (w_hdr == 16'd0) || (h_hdr == 16'd0);

  always_comb begin
    unique case (phase_e)
      rsd_pkg::PH_HEADER: begin
        if (type_bad) begin
          phase_nxt = rsd_pkg::PH_IDLE;
        end else if (hdr_more) begin
          phase_nxt = rsd_pkg::PH_HEADER;
        end else if (hdr_empty) begin
          phase_nxt = rsd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rsd_pkg::PH_COUNT;
        end
      end
      rsd_pkg::PH_COUNT: phase_nxt = rsd_pkg::PH_JUMP;
      rsd_pkg::PH_JUMP: begin
        if (run_ok && !shadow_img) begin
          phase_nxt = rsd_pkg::PH_LOW;
        end else if (b[rsd_pkg::LINE_END_BIT] && img_end) begin
          phase_nxt = rsd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rsd_pkg::PH_COUNT;
        end
      end
      rsd_pkg::PH_LOW: phase_nxt = rsd_pkg::PH_HIGH;
      rsd_pkg::PH_HIGH: begin
        if (!pix_last) begin
          phase_nxt = rsd_pkg::PH_LOW;
        end else if (jump_r[rsd_pkg::LINE_END_BIT] && img_end) begin
          phase_nxt = rsd_pkg::PH_IDLE;
        end else begin
          phase_nxt = rsd_pkg::PH_COUNT;
        end
      end
      default: phase_nxt = rsd_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    hidx_nxt  = hidx_e;
    w_nxt     = w_hdr;
    h_nxt     = h_hdr;
    x_nxt     = x_hdr;
    y_nxt     = y_hdr;
    row_nxt   = row_r;
    col_nxt   = col_r;
    loc_nxt   = loc_r;
    rbase_nxt = rbase_r;
    run_nxt   = run_r;
    jump_nxt  = jump_r;
    pl_nxt    = pl_r;
    low_nxt   = low_r;
    emit_c    = 1'b0;
    res       = '0;
    res.kind  = rsd_pkg::KIND_RUN;

    unique case (phase_e)
      rsd_pkg::PH_HEADER: begin
        if (type_bad) begin
          w_nxt          = 16'd0;
          h_nxt          = 16'd0;
          x_nxt          = 16'd0;
          y_nxt          = 16'd0;
          emit_c         = 1'b1;
          res.kind       = rsd_pkg::KIND_HEADER;
          res.image_done = 1'b1;
        end else if (hdr_more) begin
          hidx_nxt = hidx_e + 4'd1;
        end else begin
          hidx_nxt       = 4'd0;
          row_nxt        = 16'd0;
          col_nxt        = 16'd0;
          loc_nxt        = 32'd0;
          rbase_nxt      = 32'd0;
          emit_c         = 1'b1;
          res.kind       = rsd_pkg::KIND_HEADER;
          res.image_done = hdr_empty;
        end
      end
      rsd_pkg::PH_COUNT: run_nxt = b;
      rsd_pkg::PH_JUMP: begin
        jump_nxt = b;
        loc_nxt  = loc_j;
        if (run_ok && shadow_img) begin
          loc_nxt          = loc_j + {24'd0, run_r};
          col_nxt          = col_r + {8'd0, run_r};
          emit_c           = 1'b1;
          res.address      = loc_j;
          res.run_length   = sh_inside;
          res.shadow       = 1'b1;
          res.image_done   = b[rsd_pkg::LINE_END_BIT] && img_end;
          res.out_of_range = (sh_inside < run_r);
        end else if (run_ok) begin
          pl_nxt = run_r;
        end else if (b[rsd_pkg::LINE_END_BIT] && img_end) begin
          emit_c         = 1'b1;
          res.address    = line_loc;
          res.image_done = 1'b1;
        end
        if ((!run_ok || shadow_img) && b[rsd_pkg::LINE_END_BIT]) begin
          row_nxt   = row_inc;
          loc_nxt   = line_loc;
          rbase_nxt = line_loc;
          col_nxt   = 16'd0;
        end
      end
      rsd_pkg::PH_LOW: low_nxt = b;
      rsd_pkg::PH_HIGH: begin
        loc_nxt          = loc_r + 32'd1;
        col_nxt          = col_r + 16'd1;
        pl_nxt           = pl_dec;
        emit_c           = 1'b1;
        res.address      = loc_r;
        res.colour       = {b, low_r};
        res.run_length   = 8'd1;
        res.out_of_range = (loc_r >= area_r);
        if (pix_last && jump_r[rsd_pkg::LINE_END_BIT]) begin
          row_nxt        = row_inc;
          loc_nxt        = line_loc;
          rbase_nxt      = line_loc;
          col_nxt        = 16'd0;
          res.image_done = img_end;
        end
      end
      default: ;
    endcase

    res.width    = w_nxt;
    res.height   = h_nxt;
    res.x_offset = x_nxt;
    res.y_offset = y_nxt;
  end

  assign out_space = !out_valid_r || out_ready;
  assign q_ready   = out_space || !emit_c;
  assign fire      = q_valid && q_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire && emit_c) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_type_r <= rsd_pkg::TYPE_LANDSCAPE;
      offset_odd_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsd_pkg::CFG_IDX_IMAGE_TYPE: image_type_r <= cfg_wdata;
        rsd_pkg::CFG_IDX_OFFSET_ODD: offset_odd_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= rsd_pkg::PH_HEADER;
      hidx_r      <= '0;
      w_r         <= '0;
      h_r         <= '0;
      x_r         <= '0;
      y_r         <= '0;
      row_r       <= '0;
      col_r       <= '0;
      loc_r       <= '0;
      rbase_r     <= '0;
      run_r       <= '0;
      jump_r      <= '0;
      pl_r        <= '0;
      low_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        hidx_r  <= hidx_nxt;
        w_r     <= w_nxt;
        h_r     <= h_nxt;
        x_r     <= x_nxt;
        y_r     <= y_nxt;
        row_r   <= row_nxt;
        col_r   <= col_nxt;
        loc_r   <= loc_nxt;
        rbase_r <= rbase_nxt;
        run_r   <= run_nxt;
        jump_r  <= jump_nxt;
        pl_r    <= pl_nxt;
        low_r   <= low_nxt;
      end
    end
  end

  // The area is registered from the dimensions; runs never come before it catches up.
  always_ff @(posedge clk) begin
    area_r <= {16'd0, w_r} * {16'd0, h_r};
    if (fire && emit_c) begin
      out_word_r <= res;
    end
  end

endmodule

FILE: rtl/rle_sprite_decoder_unit.sv
// Channel   Ports                          Word
// input     in_valid / in_ready            rsd_in_t: data_byte, first
// result    out_valid / out_ready          rsd_out_t: kind .. out_of_range
// config    cfg_we, cfg_index, cfg_wdata   image_type, offset_odd
//
// One record byte is taken per cycle; the decoder handles one queued byte per cycle.
// A result leaves the output register in the cycle after the decoder takes its byte.
// A stalled result holds the decoder only for bytes that make a result; the byte
// queue keeps accepting until it is full. Reset is synchronous and needs no
// clearing pass.
module rle_sprite_decoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rsd_pkg::rsd_in_t               in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rsd_pkg::rsd_out_t              out_word,
  input  logic                           cfg_we,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic             q_valid;
  logic             q_ready;
  rsd_pkg::rsd_in_t q_word;

  rsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .in_ready (in_ready),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_ready  (q_ready)
  );

  rsd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_ready (out_ready)
  );

`ifndef SYNTHESIS
  a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_valid && q_ready))
    else $error("result appeared without a decoded byte");

  a_full_queue_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input held off while the byte queue is empty");
`endif

endmodule
